>>> rtl/ps2mct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ps2mct_pkg;

  // Coordinate width default
  localparam int unsigned COORD_BITS_DEF = 12;

  // Configuration port
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'd1;
  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 13'd1024;
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 13'd768;

  // Cursor reset position, truncated to the coordinate width where used
  localparam int unsigned POS_X_RST = 512;
  localparam int unsigned POS_Y_RST = 384;

  // Word fields
  localparam int unsigned RX_W  = 8;
  localparam int unsigned OUT_W = 12;
  localparam int unsigned BTN_W = 3;

  // Flags byte layout
  localparam int unsigned SYNC_BIT  = 3;
  localparam int unsigned XSIGN_BIT = 4;
  localparam int unsigned YSIGN_BIT = 5;

  // 9-bit delta, negated for Y, needs 10 bits signed
  localparam int unsigned DELTA_W = 10;

  typedef struct packed {
    logic                      good;
    logic [BTN_W-1:0]          buttons;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
  } pkt_t;

endpackage

`default_nettype wire

>>> rtl/ps2mct_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ps2mct_byte_if import ps2mct_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [RX_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ps2mct_cursor_if import ps2mct_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] cursor_x;
  logic [OUT_W-1:0] cursor_y;
  logic [BTN_W-1:0] button_bits;

  modport source (output valid, output cursor_x, output cursor_y, output button_bits,
                  input ready);
  modport sink   (input valid, input cursor_x, input cursor_y, input button_bits,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/ps2mct_assemble.sv
`timescale 1ns / 1ps
`default_nettype none

module ps2mct_assemble import ps2mct_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic [RX_W-1:0] byte_i,
  output pkt_t                 pkt_o
);

  localparam logic [1:0] BYTE_FLAGS = 2'd0;
  localparam logic [1:0] BYTE_DX    = 2'd1;
  localparam logic [1:0] BYTE_DY    = 2'd2;

  logic [1:0]      byte_pos_q, byte_pos_d;
  logic [RX_W-1:0] held_q [2];
  logic [RX_W:0]   dx_raw, dy_raw;

  // Counter wraps after three words, no resync
  always_comb begin
    unique case (byte_pos_q)
      BYTE_FLAGS: byte_pos_d = BYTE_DX;
      BYTE_DX:    byte_pos_d = BYTE_DY;
      default:    byte_pos_d = BYTE_FLAGS;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q <= BYTE_FLAGS;
    end else if (step_i) begin
      byte_pos_q <= byte_pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && byte_pos_q == BYTE_FLAGS) begin
      held_q[0] <= byte_i;
    end
    if (step_i && byte_pos_q == BYTE_DX) begin
      held_q[1] <= byte_i;
    end
  end

  assign dx_raw = {held_q[0][XSIGN_BIT], held_q[1]};
  assign dy_raw = {held_q[0][YSIGN_BIT], byte_i};

  always_comb begin
    pkt_o.good    = (byte_pos_q == BYTE_DY) && held_q[0][SYNC_BIT];
    pkt_o.buttons = held_q[0][BTN_W-1:0];
    pkt_o.dx      = DELTA_W'($signed(dx_raw));
    pkt_o.dy      = -DELTA_W'($signed(dy_raw));
  end

endmodule

`default_nettype wire

>>> rtl/ps2mct_axis.sv
`timescale 1ns / 1ps
`default_nettype none

module ps2mct_axis import ps2mct_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic [COORD_BITS-1:0]    pos_i,
  input  wire logic signed [DELTA_W-1:0] delta_i,
  input  wire logic [CFG_W-1:0]         size_i,
  output logic [COORD_BITS-1:0]         pos_o
);

  localparam int unsigned CMP_W = (COORD_BITS + 1 > CFG_W) ? COORD_BITS + 1 : CFG_W;
  localparam int unsigned SUM_W = COORD_BITS + 2;

  logic [CMP_W-1:0]        size_ext;
  logic [CMP_W-1:0]        range;
  logic [COORD_BITS-1:0]   max_pos;
  logic signed [SUM_W-1:0] sum;

  // Highest legal coordinate: size 0 pins at 0, oversize saturates
  always_comb begin
    size_ext = CMP_W'(size_i);
    range    = CMP_W'(1) << COORD_BITS;
    if (size_ext == '0) begin
      max_pos = '0;
    end else if (size_ext > range) begin
      max_pos = '1;
    end else begin
      max_pos = COORD_BITS'(size_ext - CMP_W'(1));
    end
  end

  assign sum = $signed({2'b00, pos_i}) + SUM_W'(delta_i);

  always_comb begin
    if (sum[SUM_W-1]) begin
      pos_o = '0;
    end else if (sum > $signed({2'b00, max_pos})) begin
      pos_o = max_pos;
    end else begin
      pos_o = sum[COORD_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/ps2_mouse_packet_cursor_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

// The third byte of a packet is held in the input register, then its cursor
//   word in the output register, which offers it.
// Throughput: one byte per cycle while the output is not stalled; the only loop
//   is the position add and clamp. Reset (async, active low): byte counter 0,
//   screen 1024 x 768, cursor at 512 / 384, both pipeline registers empty.
module ps2_mouse_packet_cursor_tracker import ps2mct_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  ps2mct_byte_if.sink               rx_i,
  ps2mct_cursor_if.source           cursor_o
);

  // Screen size registers
  logic [CFG_W-1:0] width_q, height_q;

  // Input stage
  logic            s1_valid_q, s1_valid_d;
  logic [RX_W-1:0] s1_byte_q;
  logic            s1_adv;

  // Packet decode and cursor state
  pkt_t                  pkt;
  logic [COORD_BITS-1:0] pos_x_q, pos_y_q;
  logic [COORD_BITS-1:0] pos_x_d, pos_y_d;
  logic                  pkt_take;

  // Output register
  logic             out_valid_q, out_valid_d;
  logic [OUT_W-1:0] out_x_q, out_y_q;
  logic [BTN_W-1:0] out_btn_q;

  // ---------------------------------------------------------------------
  // Configuration: the user writes only while idle (not enforced), no read-back
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SCREEN_WIDTH_RST;
      height_q <= SCREEN_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCREEN_WIDTH:  width_q  <= cfg_data_i;
        CFG_SCREEN_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake. A word in the input stage moves on when it yields nothing
  // (first two bytes, or a packet without sync) or when the output register
  // is free or being drained this cycle.
  // ---------------------------------------------------------------------
  assign s1_adv     = s1_valid_q && (!pkt.good || !out_valid_q || cursor_o.ready);
  assign rx_i.ready = !s1_valid_q || s1_adv;
  assign pkt_take   = s1_adv && pkt.good;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (rx_i.valid && rx_i.ready) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      s1_byte_q <= rx_i.rx_byte;
    end
  end

  // ---------------------------------------------------------------------
  // Packet assembly: counter plus the two held bytes; decodes on byte 2
  // ---------------------------------------------------------------------
  ps2mct_assemble u_assemble (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_adv),
    .byte_i (s1_byte_q),
    .pkt_o  (pkt)
  );

  // ---------------------------------------------------------------------
  // Add and clamp per axis. Y delta arrives already negated (rows grow down).
  // ---------------------------------------------------------------------
  ps2mct_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .pos_i   (pos_x_q),
    .delta_i (pkt.dx),
    .size_i  (width_q),
    .pos_o   (pos_x_d)
  );

  ps2mct_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .pos_i   (pos_y_q),
    .delta_i (pkt.dy),
    .size_i  (height_q),
    .pos_o   (pos_y_d)
  );

  // Cursor is only touched by a good packet; a resize leaves it alone
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= COORD_BITS'(POS_X_RST);
      pos_y_q <= COORD_BITS'(POS_Y_RST);
    end else if (pkt_take) begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (pkt_take) begin
      out_valid_d = 1'b1;
    end else if (cursor_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_take) begin
      out_x_q   <= OUT_W'(pos_x_d);
      out_y_q   <= OUT_W'(pos_y_d);
      out_btn_q <= pkt.buttons;
    end
  end

  assign cursor_o.valid       = out_valid_q;
  assign cursor_o.cursor_x    = out_x_q;
  assign cursor_o.cursor_y    = out_y_q;
  assign cursor_o.button_bits = out_btn_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_out_from_pkt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pkt_take))
    else $error("output word without a good packet");

  a_out_tracks_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_take |=> (out_x_q == OUT_W'(pos_x_q)) && (out_y_q == OUT_W'(pos_y_q)))
    else $error("output word differs from cursor state");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_i.ready |-> (s1_valid_q && pkt.good && out_valid_q && !cursor_o.ready))
    else $error("input stalled without a blocked result");

  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pkt_take |=> $stable(pos_x_q) && $stable(pos_y_q))
    else $error("cursor moved without a good packet");

endmodule

`default_nettype wire
